// ===== design/base64_codec_unit_macros.svh =====
// Assertion macros shared by the checker.
`ifndef BASE64_CODEC_UNIT_MACROS_SVH
`define BASE64_CODEC_UNIT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define B64_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define B64_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/b64_pkg.sv =====
`timescale 1ns / 1ps

package b64_pkg;

  // Character codes
  localparam logic [7:0] PAD_CHAR   = 8'h3D;  // '='
  localparam logic [7:0] PLUS_CHAR  = 8'h2B;  // '+'
  localparam logic [7:0] SLASH_CHAR = 8'h2F;  // '/'

  // Register indexes (byte address / 4)
  localparam logic REG_DIRECTION = 1'b0;

  // Direction codes
  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       stream_end;
    logic       error;
  } out_item_t;

  // One group's worth of results, handed from front to back
  typedef struct packed {
    logic [3:0][7:0] data;      // data[0] goes out first
    logic [1:0]      count_m1;  // number of results minus one
    logic            last;      // group closes the message
    logic            err;       // message ended inside a quad
  } job_t;

  function automatic logic [7:0] sextet_to_char(input logic [5:0] s);
    logic [7:0] c;
    if (s < 6'd26)      c = 8'h41 + {2'b00, s};
    else if (s < 6'd52) c = 8'h61 + {2'b00, s - 6'd26};
    else if (s < 6'd62) c = 8'h30 + {2'b00, s - 6'd52};
    else if (s == 6'd62) c = PLUS_CHAR;
    else c = SLASH_CHAR;
    return c;
  endfunction

  function automatic logic [5:0] char_to_sextet(input logic [7:0] c);
    logic [5:0] s;
    if (c >= 8'h41 && c <= 8'h5A)      s = 6'(c - 8'h41);
    else if (c >= 8'h61 && c <= 8'h7A) s = 6'(c - 8'h61 + 8'd26);
    else if (c >= 8'h30 && c <= 8'h39) s = 6'(c - 8'h30 + 8'd52);
    else if (c == PLUS_CHAR)           s = 6'd62;
    else if (c == SLASH_CHAR)          s = 6'd63;
    else s = 6'd0;
    return s;
  endfunction

endpackage

// ===== design/b64_front.sv =====
`timescale 1ns / 1ps

// Gathers input items into groups and builds a job when a group closes.
module b64_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              direction,
  input  logic              clear,
  input  logic              accept,
  input  b64_pkg::in_item_t item,
  output logic              job_valid,
  output b64_pkg::job_t     job
);

  logic [23:0] acc, acc_next;
  logic [1:0]  cnt, cnt_next;
  logic        third_pad, third_pad_next;

  logic [23:0] acc_enc, acc_dec, triple;
  logic [2:0]  chars;
  logic [5:0]  sext;
  logic        is_pad, pad3;

  always_comb begin
    acc_enc = {acc[15:0], item.in_byte};
    sext    = b64_pkg::char_to_sextet(item.in_byte);
    acc_dec = {acc[17:0], sext};
    is_pad  = (item.in_byte == b64_pkg::PAD_CHAR);
    pad3    = third_pad | ((cnt == 2'd2) & is_pad);

    // align a partial byte group to the top of the triple
    case (cnt)
      2'd0: begin
        triple = {acc_enc[7:0], 16'h0000};
        chars  = 3'd2;
      end
      2'd1: begin
        triple = {acc_enc[15:0], 8'h00};
        chars  = 3'd3;
      end
      default: begin
        triple = acc_enc;
        chars  = 3'd4;
      end
    endcase

    acc_next       = acc;
    cnt_next       = cnt;
    third_pad_next = third_pad;
    job_valid      = 1'b0;
    job            = '0;
    job.last       = item.stream_last;

    if (direction == b64_pkg::DIR_ENCODE) begin
      if (cnt == 2'd2 || item.stream_last) begin
        job_valid    = 1'b1;
        job.count_m1 = 2'd3;
        for (int i = 0; i < 4; i++) begin
          job.data[i] = (3'(i) < chars) ?
                        b64_pkg::sextet_to_char(triple[23 - 6*i -: 6]) :
                        b64_pkg::PAD_CHAR;
        end
        acc_next       = '0;
        cnt_next       = '0;
        third_pad_next = 1'b0;
      end else begin
        acc_next = acc_enc;
        cnt_next = cnt + 2'd1;
      end
    end else begin
      if (cnt != 2'd3) begin
        if (item.stream_last) begin
          // message ended inside a quad
          job_valid      = 1'b1;
          job.err        = 1'b1;
          acc_next       = '0;
          cnt_next       = '0;
          third_pad_next = 1'b0;
        end else begin
          acc_next       = acc_dec;
          cnt_next       = cnt + 2'd1;
          third_pad_next = pad3;
        end
      end else begin
        job_valid      = 1'b1;
        job.count_m1   = 2'd2 - 2'(item.stream_last & is_pad)
                               - 2'(item.stream_last & pad3);
        job.data[0]    = acc_dec[23:16];
        job.data[1]    = acc_dec[15:8];
        job.data[2]    = acc_dec[7:0];
        acc_next       = '0;
        cnt_next       = '0;
        third_pad_next = 1'b0;
      end
    end
  end

  // Group state
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      acc       <= '0;
      cnt       <= '0;
      third_pad <= 1'b0;
    end else if (accept) begin
      acc       <= acc_next;
      cnt       <= cnt_next;
      third_pad <= third_pad_next;
    end
  end

endmodule

// ===== design/b64_job_queue.sv =====
`timescale 1ns / 1ps

// Small job queue between front and back.
module b64_job_queue #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  b64_pkg::job_t din,
  input  logic          rd,
  output b64_pkg::job_t dout,
  output logic          full,
  output logic          valid
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  b64_pkg::job_t   slots [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;

  assign full  = (count == CW'(DEPTH));
  assign valid = (count != '0);
  assign dout  = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (wr) slots[wr_ptr] <= din;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (rd) rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      case ({wr, rd})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== design/b64_back.sv =====
`timescale 1ns / 1ps

// Takes jobs and sends their results out one item per cycle unless a waiting result is not popped.
module b64_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  input  b64_pkg::job_t      job,
  output logic               job_take,
  input  logic               pop,
  output logic               empty,
  output b64_pkg::out_item_t out_item
);

  b64_pkg::job_t cur;
  logic          cur_valid;
  logic [1:0]    idx;
  logic          out_valid;
  logic          pop_ok, adv, cur_done, at_end;

  assign empty    = ~out_valid;
  assign pop_ok   = pop & out_valid;
  assign adv      = cur_valid & (~out_valid | pop_ok);
  assign at_end   = (idx == cur.count_m1);
  assign cur_done = adv & at_end;
  assign job_take = job_valid & (~cur_valid | cur_done);

  // Current job
  always_ff @(posedge clk) begin
    if (job_take) cur <= job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (job_take) begin
      cur_valid <= 1'b1;
      idx       <= '0;
    end else if (cur_done) begin
      cur_valid <= 1'b0;
    end else if (adv) begin
      idx <= idx + 2'd1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (adv) begin
      out_item.out_byte   <= cur.data[idx];
      out_item.run_last   <= at_end;
      out_item.stream_end <= at_end & cur.last;
      out_item.error      <= cur.err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= 1'b1;
    else if (pop_ok) out_valid <= 1'b0;
  end

endmodule

// ===== design/base64_codec_unit.sv =====
`timescale 1ns / 1ps

// Channel   | Handshake               | Payload
// ----------+-------------------------+------------------------------
// input     | push / full             | in_item (in_byte, stream_last)
// result    | pop / empty             | out_item (out_byte, run_last,
//           |                         |   stream_end, error)
// config    | psel, penable, pwrite   | paddr, pwdata, prdata, pready
//
// An input item is taken when push is high and full is low; a closing group
// gives a job of up to four results, which the back end sends one per cycle
// while the result side pops; new items are taken while earlier jobs drain.
// A job passes the job queue and current-job register before its first result.
// Reset clears group state, the job queue and the output; direction = encode.
// full follows the job queue; result stalls back up through the queue.
module base64_codec_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  b64_pkg::in_item_t  in_item,
  input  logic               pop,
  output logic               empty,
  output b64_pkg::out_item_t out_item,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic          direction;
  logic          cfg_wr, dir_wr, accept;
  logic          front_valid, q_full, q_valid, q_take;
  b64_pkg::job_t front_job, q_job;

  // Register port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign dir_wr = cfg_wr & (paddr[2] == b64_pkg::REG_DIRECTION);
  assign prdata = (paddr[2] == b64_pkg::REG_DIRECTION) ? {31'b0, direction} : '0;

  always_ff @(posedge clk) begin
    if (rst) direction <= b64_pkg::DIR_ENCODE;
    else if (dir_wr) direction <= pwdata[0];
  end

  assign full   = q_full;
  assign accept = push & ~q_full;

  b64_front u_front (
    .clk       (clk),
    .rst       (rst),
    .direction (direction),
    .clear     (dir_wr),
    .accept    (accept),
    .item      (in_item),
    .job_valid (front_valid),
    .job       (front_job)
  );

  b64_job_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (accept & front_valid),
    .din   (front_job),
    .rd    (q_take),
    .dout  (q_job),
    .full  (q_full),
    .valid (q_valid)
  );

  b64_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_valid),
    .job       (q_job),
    .job_take  (q_take),
    .pop       (pop),
    .empty     (empty),
    .out_item  (out_item)
  );

endmodule

// ===== design/b64_checker.sv =====
`timescale 1ns / 1ps
`include "base64_codec_unit_macros.svh"

// Port-level checks on the result channel.
module b64_checker (
  input logic               clk,
  input logic               rst,
  input logic               pop,
  input logic               empty,
  input b64_pkg::out_item_t out_item
);

  // A waiting result is not withdrawn or changed
  `B64_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(out_item), "result changed while waiting")

  // An error result closes both the run and the message with a zero byte
  `B64_ASSERT_NOW(a_err_shape, !empty && out_item.error, out_item.run_last && out_item.stream_end && out_item.out_byte == 8'h00, "malformed error item")

  // End of message is always the last item of its run
  `B64_ASSERT_NOW(a_end_run, !empty && out_item.stream_end, out_item.run_last, "stream_end without run_last")

endmodule

bind base64_codec_unit b64_checker u_b64_checker (.*);

// ===== test/tb_base64_codec_unit.sv =====
`timescale 1ns / 1ps

module tb_base64_codec_unit;

  // Register map as the testbench sees it
  localparam logic [2:0] DIR_ADDR   = {b64_pkg::REG_DIRECTION, 2'b00};
  localparam logic [2:0] STRAY_ADDR = 3'd4;  // no register decoded here
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 175;
  localparam int PHASE_ITEMS   = 25;
  localparam int LONG_HOLD     = 60;

  // Directed plan: an item, a direction write, or a write to an unused address
  typedef enum logic [1:0] {ROW_ITEM, ROW_DIR, ROW_STRAY} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [7:0]  data;       // item byte, or value written
    logic        last;
    logic [2:0]  n_typed;    // 0: results come from the predictor
    logic        typed_err;
    logic [31:0] typed;      // first result in the top byte
  } row_t;

  localparam int PLAN_ROWS = 26;

  row_t plan [PLAN_ROWS] = '{
    // encode: lone byte, pair and full triple, each closing a message
    '{ROW_ITEM, 8'h00, 1'b1, 3'd4, 1'b0,
      {"A", "A", b64_pkg::PAD_CHAR, b64_pkg::PAD_CHAR}},
    '{ROW_ITEM, 8'hFF, 1'b0, 3'd0, 1'b0, 32'h0},
    '{ROW_ITEM, 8'hFF, 1'b1, 3'd4, 1'b0,
      {b64_pkg::SLASH_CHAR, b64_pkg::SLASH_CHAR, "8", b64_pkg::PAD_CHAR}},
    '{ROW_ITEM, 8'hFF, 1'b0, 3'd0, 1'b0, 32'h0},
    '{ROW_ITEM, 8'hFF, 1'b0, 3'd0, 1'b0, 32'h0},
    '{ROW_ITEM, 8'hFF, 1'b1, 3'd4, 1'b0,
      {b64_pkg::SLASH_CHAR, b64_pkg::SLASH_CHAR, b64_pkg::SLASH_CHAR, b64_pkg::SLASH_CHAR}},
    // partial group survives a write to an unused address
    '{ROW_ITEM, 8'h12, 1'b0, 3'd0, 1'b0, 32'h0},
    '{ROW_STRAY, 8'h01, 1'b0, 3'd0, 1'b0, 32'h0},
    '{ROW_ITEM, 8'h34, 1'b0, 3'd0, 1'b0, 32'h0},
    '{ROW_ITEM, 8'h56, 1'b0, 3'd0, 1'b0, 32'h0},
    // partial group thrown away by the direction write
    '{ROW_ITEM, 8'h9A, 1'b0, 3'd0, 1'b0, 32'h0},
    '{ROW_DIR, {7'd0, b64_pkg::DIR_DECODE}, 1'b0, 3'd0, 1'b0, 32'h0},
    // decode: padding inside a quad that does not end the message
    '{ROW_ITEM, b64_pkg::SLASH_CHAR, 1'b0, 3'd0, 1'b0, 32'h0},
    '{ROW_ITEM, b64_pkg::PLUS_CHAR, 1'b0, 3'd0, 1'b0, 32'h0},
    '{ROW_ITEM, b64_pkg::PAD_CHAR, 1'b0, 3'd0, 1'b0, 32'h0},
    '{ROW_ITEM, b64_pkg::PAD_CHAR, 1'b0, 3'd0, 1'b0, 32'h0},
    // final quad, pad in third position only
    '{ROW_ITEM, "Q", 1'b0, 3'd0, 1'b0, 32'h0},
    '{ROW_ITEM, "Q", 1'b0, 3'd0, 1'b0, 32'h0},
    '{ROW_ITEM, b64_pkg::PAD_CHAR, 1'b0, 3'd0, 1'b0, 32'h0},
    '{ROW_ITEM, "A", 1'b1, 3'd0, 1'b0, 32'h0},
    // final quad with two pads
    '{ROW_ITEM, "Q", 1'b0, 3'd0, 1'b0, 32'h0},
    '{ROW_ITEM, "Q", 1'b0, 3'd0, 1'b0, 32'h0},
    '{ROW_ITEM, b64_pkg::PAD_CHAR, 1'b0, 3'd0, 1'b0, 32'h0},
    '{ROW_ITEM, b64_pkg::PAD_CHAR, 1'b1, 3'd1, 1'b0, {8'h41, 24'h0}},
    // message ends inside a quad, bytes outside the alphabet
    '{ROW_ITEM, 8'hFF, 1'b0, 3'd0, 1'b0, 32'h0},
    '{ROW_ITEM, 8'h00, 1'b1, 3'd1, 1'b1, 32'h0}
  };

  logic               clk;
  logic               rst;
  logic               push;
  logic               full;
  b64_pkg::in_item_t  in_item;
  logic               pop;
  logic               empty;
  b64_pkg::out_item_t out_item;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  base64_codec_unit dut (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .pop     (pop),
    .empty   (empty),
    .out_item(out_item),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Codec state as predicted
  logic        dir;
  logic [23:0] acc;
  logic [1:0]  grp;
  logic        pad3;

  string       alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  b64_pkg::out_item_t pending_symbols [$];
  int          mismatches = 0;
  int          items_sent = 0;
  bit          calm = 1'b0;   // no idling on either side
  int          long_hold = 0; // next receiver stall, when set

  function automatic logic [7:0] glyph(input logic [5:0] s);
    return alphabet[s];
  endfunction

  function automatic logic [5:0] sextet_of(input logic [7:0] c);
    for (int i = 0; i < 64; i++) begin
      if (alphabet[i] == c) return 6'(i);
    end
    return 6'd0;
  endfunction

  function automatic void forget_group();
    acc  = '0;
    grp  = '0;
    pad3 = 1'b0;
  endfunction

  // Works out the results one item causes; returns how many
  function automatic int transcode_item(input b64_pkg::in_item_t it,
                                        output b64_pkg::out_item_t res [4]);
    int          held;
    int          nb;
    logic [23:0] triple;
    if (dir == b64_pkg::DIR_ENCODE) begin
      acc  = {acc[15:0], it.in_byte};
      held = grp + 1;
      if (held < 3 && !it.stream_last) begin
        grp = 2'(held);
        return 0;
      end
      triple = acc << (8 * (3 - held));
      for (int i = 0; i < 4; i++) begin
        res[i].out_byte   = (i <= held) ? glyph(6'(triple >> (18 - 6 * i)))
                                        : b64_pkg::PAD_CHAR;
        res[i].run_last   = (i == 3);
        res[i].stream_end = it.stream_last && (i == 3);
        res[i].error      = 1'b0;
      end
      forget_group();
      return 4;
    end
    // decode
    if (grp == 2'd2 && it.in_byte == b64_pkg::PAD_CHAR) pad3 = 1'b1;
    acc = {acc[17:0], sextet_of(it.in_byte)};
    if (grp < 2'd3) begin
      if (it.stream_last) begin
        forget_group();
        res[0] = '{out_byte: 8'h00, run_last: 1'b1, stream_end: 1'b1, error: 1'b1};
        return 1;
      end
      grp = grp + 2'd1;
      return 0;
    end
    nb = 3;
    if (it.stream_last) begin
      if (it.in_byte == b64_pkg::PAD_CHAR) nb--;
      if (pad3) nb--;
    end
    for (int i = 0; i < nb; i++) begin
      res[i].out_byte   = 8'(acc >> (16 - 8 * i));
      res[i].run_last   = (i == nb - 1);
      res[i].stream_end = it.stream_last && (i == nb - 1);
      res[i].error      = 1'b0;
    end
    forget_group();
    return nb;
  endfunction

  // Offers one item after a random gap; queues its results once taken
  task automatic send_item(input b64_pkg::in_item_t it, input logic [2:0] n_typed,
                           input logic typed_err, input logic [31:0] typed);
    int                 gap;
    int                 cnt;
    b64_pkg::out_item_t res [4];
    gap = calm ? 0 : $urandom_range(0, 3);
    @(negedge clk);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push    <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (full);
    cnt = transcode_item(it, res);
    if (n_typed != 0) begin
      for (int k = 0; k < n_typed; k++) begin
        pending_symbols.push_back('{out_byte: typed[31 - 8 * k -: 8],
                                    run_last: (k == n_typed - 1),
                                    stream_end: it.stream_last && (k == n_typed - 1),
                                    error: typed_err});
      end
    end else begin
      for (int k = 0; k < cnt; k++) pending_symbols.push_back(res[k]);
    end
    items_sent++;
  endtask

  // Stops offering and waits until every owed result is out
  task automatic drain();
    @(negedge clk);
    push <= 1'b0;
    while (pending_symbols.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write, then read back the direction register
  task automatic program_reg(input logic [2:0] addr, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == DIR_ADDR) begin
      dir = value[0];
      forget_group();
    end
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= DIR_ADDR;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {31'd0, dir}) begin
      $error("prdata: expected %h, got %h", {31'd0, dir}, prdata);
      mismatches++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result side: random stalls, compares each taken item with the oldest owed
  initial begin : result_side
    int                 stall;
    b64_pkg::out_item_t got;
    b64_pkg::out_item_t want;
    pop = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (long_hold > 0) begin
        stall     = long_hold;
        long_hold = 0;
      end else begin
        stall = calm ? 0 : $urandom_range(0, 3);
      end
      @(negedge clk);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      got = out_item;
      if (pending_symbols.size() == 0) begin
        $error("result with nothing owed: out_byte %h", got.out_byte);
        mismatches++;
      end else begin
        want = pending_symbols.pop_front();
        if (got.out_byte !== want.out_byte) begin
          $error("out_byte: expected %h, got %h", want.out_byte, got.out_byte);
          mismatches++;
        end
        if (got.run_last !== want.run_last) begin
          $error("run_last: expected %b, got %b", want.run_last, got.run_last);
          mismatches++;
        end
        if (got.stream_end !== want.stream_end) begin
          $error("stream_end: expected %b, got %b", want.stream_end, got.stream_end);
          mismatches++;
        end
        if (got.error !== want.error) begin
          $error("error: expected %b, got %b", want.error, got.error);
          mismatches++;
        end
      end
    end
  end

  // Stimulus: directed plan, then random phases
  initial begin : stimulus
    b64_pkg::in_item_t it;
    int         quota;
    int         phase;
    int         len;
    int         nq;
    int         pad;
    logic [7:0] ch;
    rst     = 1'b1;
    push    = 1'b0;
    in_item = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    dir     = b64_pkg::DIR_ENCODE;
    forget_group();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int r = 0; r < PLAN_ROWS; r++) begin
      case (plan[r].kind)
        ROW_ITEM: begin
          it = '{in_byte: plan[r].data, stream_last: plan[r].last};
          send_item(it, plan[r].n_typed, plan[r].typed_err, plan[r].typed);
        end
        ROW_DIR: begin
          drain();
          program_reg(DIR_ADDR, {24'd0, plan[r].data});
        end
        default: begin
          drain();
          program_reg(STRAY_ADDR, {24'd0, plan[r].data});
        end
      endcase
    end

    phase = 0;
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      drain();
      // both directions early on, random afterwards
      program_reg(DIR_ADDR, (phase == 0) ? {31'd0, b64_pkg::DIR_ENCODE} :
                            (phase == 1) ? {31'd0, b64_pkg::DIR_DECODE} :
                                           32'($urandom_range(0, 1)));
      calm = ($urandom_range(0, 3) == 0);
      if (phase == 1) long_hold = LONG_HOLD;
      quota = items_sent + PHASE_ITEMS;
      while (items_sent < quota) begin
        if (dir == b64_pkg::DIR_ENCODE) begin
          len = $urandom_range(1, 8);
          for (int k = 0; k < len; k++) begin
            it = '{in_byte: 8'($urandom_range(0, 255)), stream_last: (k == len - 1)};
            send_item(it, 3'd0, 1'b0, 32'h0);
          end
        end else if ($urandom_range(0, 4) == 0) begin
          // noise: any bytes, usually ending inside a quad
          len = $urandom_range(1, 9);
          for (int k = 0; k < len; k++) begin
            it = '{in_byte: 8'($urandom_range(0, 255)), stream_last: (k == len - 1)};
            send_item(it, 3'd0, 1'b0, 32'h0);
          end
        end else begin
          // mostly well-formed quads, final one padded by zero, one or two
          nq  = $urandom_range(1, 3);
          pad = $urandom_range(0, 2);
          for (int q = 0; q < nq; q++) begin
            for (int k = 0; k < 4; k++) begin
              ch = ($urandom_range(0, 15) == 0) ? b64_pkg::PAD_CHAR
                                                : glyph(6'($urandom_range(0, 63)));
              if (q == nq - 1 && ((k == 3 && pad > 0) || (k == 2 && pad == 2)))
                ch = b64_pkg::PAD_CHAR;
              it = '{in_byte: ch, stream_last: (q == nq - 1 && k == 3)};
              send_item(it, 3'd0, 1'b0, 32'h0);
            end
          end
        end
      end
      // sometimes leave a group open for the next direction write to discard
      if ($urandom_range(0, 2) == 0) begin
        len = $urandom_range(1, (dir == b64_pkg::DIR_ENCODE) ? 2 : 3);
        for (int k = 0; k < len; k++) begin
          it = '{in_byte: 8'($urandom_range(0, 255)), stream_last: 1'b0};
          send_item(it, 3'd0, 1'b0, 32'h0);
        end
      end
      phase++;
    end

    drain();
    if (mismatches == 0) begin
      $display("base64_codec_unit test passed");
    end else begin
      $display("base64_codec_unit test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("base64_codec_unit test failed");
    $finish;
  end

endmodule
